// ===== rtl/mwlg_pkg.sv =====
package mwlg_pkg;

  // word buffer and score sizing
  localparam int unsigned MAX_WORD_BYTES = 8;
  localparam int unsigned SCORE_WIDTH    = 16;
  localparam int unsigned WORD_W         = 8 * MAX_WORD_BYTES;
  localparam int unsigned LEN_W          = $clog2(MAX_WORD_BYTES + 1);

  localparam int unsigned N_GERMAN  = 66;
  localparam int unsigned N_ENGLISH = 71;

  // resolved / requested language codes
  typedef enum logic [1:0] {
    LANG_AUTO  = 2'd0,
    LANG_DE    = 2'd1,
    LANG_EN    = 2'd2,
    LANG_OTHER = 2'd3
  } lang_e;

  // marker hits for one finished word
  typedef struct packed {
    logic german;
    logic english;
  } hit_t;

  // words are packed with the first byte most significant, zero filled above
  localparam logic [WORD_W-1:0] GERMAN_MARKS [N_GERMAN] = '{
    WORD_W'("aber"), WORD_W'("auch"), WORD_W'("auf"), WORD_W'("aus"),
    WORD_W'("bei"), WORD_W'("bin"), WORD_W'("bis"), WORD_W'("das"),
    WORD_W'("dass"), WORD_W'("dem"), WORD_W'("den"), WORD_W'("der"),
    WORD_W'("des"), WORD_W'("die"), WORD_W'("dies"), WORD_W'("doch"),
    WORD_W'("du"), WORD_W'("ein"), WORD_W'("eine"), WORD_W'("einen"),
    WORD_W'("einer"), WORD_W'("er"), WORD_W'("erstens"), WORD_W'("es"),
    WORD_W'({8'h66, 8'hC3, 8'hBC, 8'h72}), WORD_W'("gut"), WORD_W'("haben"),
    WORD_W'("hat"), WORD_W'("heute"), WORD_W'("hier"), WORD_W'("ich"),
    WORD_W'("im"), WORD_W'("in"), WORD_W'("ist"), WORD_W'("kann"),
    WORD_W'("kein"), WORD_W'("keine"), WORD_W'("man"), WORD_W'("mein"),
    WORD_W'("mit"),
    WORD_W'({8'h6D, 8'hC3, 8'hB6, 8'h63, 8'h68, 8'h74, 8'h65}),
    WORD_W'("nicht"), WORD_W'("noch"), WORD_W'("oder"), WORD_W'("schon"),
    WORD_W'("sehr"), WORD_W'("sie"), WORD_W'("sind"), WORD_W'("sondern"),
    WORD_W'({8'hC3, 8'hBC, 8'h62, 8'h65, 8'h72}),
    WORD_W'("und"), WORD_W'("uns"), WORD_W'("von"), WORD_W'("vor"),
    WORD_W'("war"), WORD_W'("was"), WORD_W'("wenn"), WORD_W'("werden"),
    WORD_W'("wie"), WORD_W'("wir"), WORD_W'("wird"),
    WORD_W'({8'h77, 8'hC3, 8'hBC, 8'h72, 8'h64, 8'h65}),
    WORD_W'("zu"), WORD_W'("zum"), WORD_W'("zur"), WORD_W'("zweitens")
  };

  localparam logic [WORD_W-1:0] ENGLISH_MARKS [N_ENGLISH] = '{
    WORD_W'("a"), WORD_W'("also"), WORD_W'("an"), WORD_W'("and"),
    WORD_W'("are"), WORD_W'("as"), WORD_W'("at"), WORD_W'("be"),
    WORD_W'("being"), WORD_W'("but"), WORD_W'("by"), WORD_W'("can"),
    WORD_W'("do"), WORD_W'("does"), WORD_W'("exactly"), WORD_W'("first"),
    WORD_W'("for"), WORD_W'("fourth"), WORD_W'("from"), WORD_W'("good"),
    WORD_W'("had"), WORD_W'("has"), WORD_W'("have"), WORD_W'("he"),
    WORD_W'("hello"), WORD_W'("her"), WORD_W'("here"), WORD_W'("his"),
    WORD_W'("how"), WORD_W'("i"), WORD_W'("if"), WORD_W'("in"),
    WORD_W'("is"), WORD_W'("it"), WORD_W'("like"), WORD_W'("me"),
    WORD_W'("my"), WORD_W'("new"), WORD_W'("not"), WORD_W'("of"),
    WORD_W'("on"), WORD_W'("or"), WORD_W'("our"), WORD_W'("second"),
    WORD_W'("she"), WORD_W'("so"), WORD_W'("that"), WORD_W'("the"),
    WORD_W'("their"), WORD_W'("them"), WORD_W'("then"), WORD_W'("they"),
    WORD_W'("third"), WORD_W'("this"), WORD_W'("to"), WORD_W'("today"),
    WORD_W'("tomorrow"), WORD_W'("want"), WORD_W'("was"), WORD_W'("we"),
    WORD_W'("well"), WORD_W'("what"), WORD_W'("when"), WORD_W'("where"),
    WORD_W'("which"), WORD_W'("will"), WORD_W'("with"), WORD_W'("world"),
    WORD_W'("would"), WORD_W'("you"), WORD_W'("your")
  };

endpackage

// ===== rtl/mwlg_match.sv =====
module mwlg_match
  import mwlg_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  input  logic              overlong_i,
  output hit_t              hit_o
);

  logic [N_GERMAN-1:0]  ger_eq;
  logic [N_ENGLISH-1:0] eng_eq;

  // parallel compare against both marker lists
  always_comb begin
    for (int i = 0; i < N_GERMAN; i++) begin
      ger_eq[i] = (word_i == GERMAN_MARKS[i]);
    end
    for (int i = 0; i < N_ENGLISH; i++) begin
      eng_eq[i] = (word_i == ENGLISH_MARKS[i]);
    end
  end

  // an overlong word never matches
  assign hit_o.german  = |ger_eq && !overlong_i;
  assign hit_o.english = |eng_eq && !overlong_i;

endmodule

// ===== rtl/marker_word_language_guard_core.sv =====
// channel | direction | handshake                   | payload
// input   | in        | in_valid_i / in_stall_o     | text_byte_i, has_byte_i,
//         |           |                             | end_of_text_i, is_output_text_i
// result  | out       | out_valid_o / out_stall_i   | german_score_o, english_score_o,
//         |           |                             | language_o, preserves_o,
//         |           |                             | was_output_pass_o
// config  | in        | cfg_we_i                    | cfg_wdata_i
//
// one item per cycle unless the result side stalls; an item is held in the input
// register, then the word match and score update run combinationally into the result register
// a result is registered when its end-of-text item leaves the input register
// reset clears the word buffer, scores, resolved language and register
// a stalled result holds the input register, which stalls the input side
module marker_word_language_guard_core
  import mwlg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             text_byte_i,
  input  logic                   has_byte_i,
  input  logic                   end_of_text_i,
  input  logic                   is_output_text_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SCORE_WIDTH-1:0] german_score_o,
  output logic [SCORE_WIDTH-1:0] english_score_o,
  output logic [1:0]             language_o,
  output logic                   preserves_o,
  output logic                   was_output_pass_o
);

  localparam int unsigned CW = SCORE_WIDTH + 2;

  lang_e                  req_q;
  lang_e                  res_q, res_d;
  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   has_q, eot_q, isout_q;
  logic [WORD_W-1:0]      word_q, word_d, word_n;
  logic [LEN_W-1:0]       len_q, len_d, len_n;
  logic                   ovl_q, ovl_d, ovl_n;
  logic [SCORE_WIDTH-1:0] ger_q, ger_d, ger_n;
  logic [SCORE_WIDTH-1:0] eng_q, eng_d, eng_n;
  logic                   out_valid_q;
  logic [SCORE_WIDTH-1:0] out_ger_q, out_eng_q;
  lang_e                  out_lang_q, out_lang_d;
  logic                   out_pres_q, out_pres_d, out_wop_q;
  logic                   adv, proc, accept, is_wb, finish;
  logic [7:0]             low_b;
  logic [CW-1:0]          g_x, e_x;
  hit_t                   hit;

  // handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= LANG_AUTO;
    end else if (cfg_we_i) begin
      req_q <= lang_e'(cfg_wdata_i);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= text_byte_i;
      has_q   <= has_byte_i;
      eot_q   <= end_of_text_i;
      isout_q <= is_output_text_i;
    end
  end

  // byte class and lowercase
  always_comb begin
    is_wb = (byte_q inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], [8'h80:8'hFF]})
            || (byte_q == 8'h27);
    low_b = (byte_q inside {[8'h41:8'h5A]}) ? byte_q + 8'd32 : byte_q;
  end

  // word buffer with the new byte shifted in
  always_comb begin
    word_n = word_q;
    len_n  = len_q;
    ovl_n  = ovl_q;
    if (has_q && is_wb) begin
      if (len_q < LEN_W'(MAX_WORD_BYTES)) begin
        word_n = {word_q[WORD_W-9:0], low_b};
        len_n  = len_q + LEN_W'(1);
      end else begin
        ovl_n = 1'b1;
      end
    end
    finish = (has_q && !is_wb) || eot_q;
  end

  mwlg_match u_match (
    .word_i     (word_n),
    .overlong_i (ovl_n),
    .hit_o      (hit)
  );

  // saturating score update
  always_comb begin
    ger_n = ger_q;
    eng_n = eng_q;
    if (finish && len_n != '0) begin
      if (hit.german && ger_q != '1) begin
        ger_n = ger_q + SCORE_WIDTH'(1);
      end
      if (hit.english && eng_q != '1) begin
        eng_n = eng_q + SCORE_WIDTH'(1);
      end
    end
    g_x = CW'(ger_n);
    e_x = CW'(eng_n);
  end

  // language resolution and output check
  always_comb begin
    res_d      = res_q;
    out_pres_d = 1'b1;
    if (!isout_q) begin
      if (req_q != LANG_AUTO) begin
        res_d = req_q;
      end else if (g_x >= CW'(3) && g_x >= {e_x[CW-2:0], 1'b0} + CW'(1)) begin
        res_d = LANG_DE;
      end else if (e_x >= CW'(3) && e_x >= {g_x[CW-2:0], 1'b0} + CW'(1)) begin
        res_d = LANG_EN;
      end else begin
        res_d = LANG_AUTO;
      end
    end else begin
      case (res_q)
        LANG_DE: begin
          out_pres_d = !(e_x >= CW'(4) && e_x >= {g_x[CW-2:0], 1'b0} + CW'(2));
        end
        LANG_EN: begin
          out_pres_d = !(g_x >= CW'(4) && g_x >= {e_x[CW-2:0], 1'b0} + CW'(2));
        end
        default: begin
          out_pres_d = 1'b1;
        end
      endcase
    end
    out_lang_d = res_d;
  end

  // next word and score state
  always_comb begin
    word_d = finish ? '0 : word_n;
    len_d  = finish ? '0 : len_n;
    ovl_d  = finish ? 1'b0 : ovl_n;
    ger_d  = eot_q ? '0 : ger_n;
    eng_d  = eot_q ? '0 : eng_n;
  end

  // processing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      len_q  <= '0;
      ovl_q  <= 1'b0;
      ger_q  <= '0;
      eng_q  <= '0;
      res_q  <= LANG_AUTO;
    end else if (proc) begin
      word_q <= word_d;
      len_q  <= len_d;
      ovl_q  <= ovl_d;
      ger_q  <= ger_d;
      eng_q  <= eng_d;
      if (eot_q) begin
        res_q <= res_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && eot_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && eot_q) begin
      out_ger_q  <= ger_n;
      out_eng_q  <= eng_n;
      out_lang_q <= out_lang_d;
      out_pres_q <= out_pres_d;
      out_wop_q  <= isout_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign german_score_o    = out_ger_q;
  assign english_score_o   = out_eng_q;
  assign language_o        = out_lang_q;
  assign preserves_o       = out_pres_q;
  assign was_output_pass_o = out_wop_q;

  // a new result only follows a processed end-of-text item
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc && eot_q))
    else $error("result without end-of-text item");

  // scores clear after a text closes
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && eot_q) |=> (ger_q == '0 && eng_q == '0 && len_q == '0))
    else $error("scores not cleared after text end");

  // overlong flag only on a full buffer
  a_ovl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovl_q |-> (len_q == LEN_W'(MAX_WORD_BYTES)))
    else $error("overlong flag with partial word");

  // a source-pass result always reports preserved
  a_pres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_wop_q) |-> out_pres_q)
    else $error("source pass result not preserved");

endmodule
